// ===== rtl/core/hgg_pkg.sv =====
// ----------------------------------------------------------------------------
// hgg_pkg: shared types and constants for the hip gait generator
// Field widths, register indexes, mode codes, step counts and the duty clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package hgg_pkg;

    localparam int DUTY_W    = 16;                    // Q0.16 duty fraction
    localparam int MS_W      = 16;                    // millisecond counts
    localparam int HALF_W    = MS_W - 1;              // half period
    localparam int SUM_W     = MS_W + 1;              // phase + elapsed
    localparam int WAVE_W    = DUTY_W + 2;            // signed wave, +-2*swing span
    localparam int POSE_W    = DUTY_W + 3;            // signed pre-clamp duty
    localparam int CFG_IDX_W = 3;
    localparam int NUM_LEGS  = 4;
    localparam int IN_DATA_W = 24;                    // elapsed_ms, mode, pad
    localparam int OUT_DATA_W = NUM_LEGS * DUTY_W;

    // remainder unit: one dividend bit per cycle
    localparam int MOD_STEPS = SUM_W;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    // wave lane: multiplier bits, then quotient bits
    localparam int LANE_MUL_STEPS = HALF_W;
    localparam int LANE_DIV_STEPS = DUTY_W + 1;
    localparam int LANE_STEPS     = LANE_MUL_STEPS + LANE_DIV_STEPS;
    localparam int LANE_CNT_W     = $clog2(LANE_STEPS);
    localparam int PROD_W         = HALF_W + LANE_DIV_STEPS;

    localparam logic [MS_W-1:0]   RST_PERIOD = 16'd3000;
    localparam logic [DUTY_W-1:0] RST_SWING  = 16'd1311;
    localparam logic [DUTY_W-1:0] RST_STAND  = 16'd4588;
    localparam logic [DUTY_W-1:0] RST_MIN    = 16'd1966;
    localparam logic [DUTY_W-1:0] RST_MAX    = 16'd7209;
    localparam logic [MS_W-1:0]   MIN_PERIOD = 16'd2;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 3'd0,
        CFG_SWING  = 3'd1,
        CFG_STAND  = 3'd2,
        CFG_MIN    = 3'd3,
        CFG_MAX    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_STAND = 2'd0,
        MODE_PRONE = 2'd1,
        MODE_FWD   = 2'd2,
        MODE_BACK  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_WAVE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                   start;
        logic [MS_W-1:0]        q;      // phase within the cycle
        logic [HALF_W-1:0]      half;
        logic [DUTY_W-1:0]      swing;
    } t_lane_req;

    // Low clamp first, then high clamp: min > max gives max everywhere.
    function automatic logic [DUTY_W-1:0] clamp_duty(
        input logic signed [POSE_W-1:0] v,
        input logic [DUTY_W-1:0]        lo,
        input logic [DUTY_W-1:0]        hi
    );
        logic signed [POSE_W-1:0] t;
        t = v;
        if (t < $signed({3'b000, lo})) t = $signed({3'b000, lo});
        if (t > $signed({3'b000, hi})) t = $signed({3'b000, hi});
        return t[DUTY_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hgg_mod_unit.sv =====
// ----------------------------------------------------------------------------
// hgg_mod_unit: bit-serial remainder
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module hgg_mod_unit (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [hgg_pkg::SUM_W-1:0]   i_dividend,
    input  wire [hgg_pkg::MS_W-1:0]    i_divisor,
    output logic                       o_done,
    output logic [hgg_pkg::MS_W-1:0]   o_rem
);
    import hgg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_num;
    logic [MS_W-1:0]      r_rem;

    logic [SUM_W-1:0]     trial;
    logic                 ge;
    logic [SUM_W-1:0]     diff;

    assign trial = {r_rem, r_num[SUM_W-1]};
    assign ge    = trial >= {1'b0, i_divisor};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MOD_CNT_W'(MOD_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[SUM_W-2:0], 1'b0};
            r_rem <= ge ? diff[MS_W-1:0] : trial[MS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/core/hgg_wave_lane.sv =====
// ----------------------------------------------------------------------------
// hgg_wave_lane: triangle wave sample, bit-serial
// Shift-add multiply (one multiplier bit a cycle) followed by restoring
// division by the half period (one quotient bit a cycle) in one register.
// ----------------------------------------------------------------------------
`default_nettype none

module hgg_wave_lane (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  hgg_pkg::t_lane_req                 i_req,
    output logic                               o_done,
    output logic signed [hgg_pkg::WAVE_W-1:0]  o_wave
);
    import hgg_pkg::*;

    logic                       r_busy;
    logic                       r_done;
    logic [LANE_CNT_W-1:0]      r_cnt;
    logic                       r_fall;
    logic [DUTY_W:0]            r_mcand;   // swing or 2*swing
    logic [PROD_W-1:0]          r_prod;    // {hi, multiplier} then {rem, num/quot}
    logic [HALF_W-1:0]          r_half;
    logic [DUTY_W-1:0]          r_swing;
    logic signed [WAVE_W-1:0]   r_wave;

    logic                       fall;
    logic [MS_W-1:0]            q_off;
    logic [DUTY_W+1:0]          mul_sum;
    logic [HALF_W:0]            trial;
    logic                       ge;
    logic [HALF_W:0]            diff;
    logic [LANE_DIV_STEPS-1:0]  quot;

    assign fall  = i_req.q >= {1'b0, i_req.half};
    assign q_off = fall ? (i_req.q - {1'b0, i_req.half}) : i_req.q;

    assign mul_sum = {1'b0, r_prod[PROD_W-1:HALF_W]}
                   + (r_prod[0] ? {1'b0, r_mcand} : '0);

    assign trial = {r_prod[PROD_W-1:LANE_DIV_STEPS], r_prod[LANE_DIV_STEPS-1]};
    assign ge    = trial >= {1'b0, r_half};
    assign diff  = trial - {1'b0, r_half};
    assign quot  = {r_prod[LANE_DIV_STEPS-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LANE_CNT_W'(LANE_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_fall  <= fall;
            r_mcand <= fall ? {i_req.swing, 1'b0} : {1'b0, i_req.swing};
            r_prod  <= {{(PROD_W-HALF_W){1'b0}}, q_off[HALF_W-1:0]};
            r_half  <= i_req.half;
            r_swing <= i_req.swing;
        end else if (r_busy) begin
            if (r_cnt < LANE_CNT_W'(LANE_MUL_STEPS)) begin
                r_prod <= {mul_sum, r_prod[HALF_W-1:1]};
            end else begin
                r_prod <= {ge ? diff[HALF_W-1:0] : trial[HALF_W-1:0], quot};
            end
            if (r_cnt == LANE_CNT_W'(LANE_STEPS - 1)) begin
                // rising half: quot; falling half: swing - quot
                r_wave <= r_fall
                    ? ($signed({2'b00, r_swing}) - $signed({1'b0, quot}))
                    : $signed({1'b0, quot});
            end
        end
    end

    assign o_done = r_done;
    assign o_wave = r_wave;

endmodule

`default_nettype wire

// ===== rtl/core/quadruped_hip_gait_generator.sv =====
// ----------------------------------------------------------------------------
// quadruped_hip_gait_generator: four hip-servo duties for a walking gait
// Mode control, phase tracking, two wave lanes and the clamped output beat.
// ----------------------------------------------------------------------------
// Input beats carry either a time tick (tuser low, elapsed_ms in tdata) or a
// mode change (tuser high, mode in tdata). Stand and prone mode changes set the
// pose registers and load the output register from the emit state once it is
// free; walk mode changes clear the phase and yield nothing, as do ticks
// outside a walk mode. A walk tick goes first through the bit-serial remainder
// unit that folds phase + elapsed into the period, then through the two wave
// lanes running side by side (shift-add multiply bits, then quotient bits, in
// each), then into the pose registers, and is clamped into the output register
// once it is free.
// One item is worked on at a time; the next beat is taken as soon as the
// result sits in the output register, even if the sink has not yet taken it.
// Configuration writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module quadruped_hip_gait_generator (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration write port
    input  wire                                  i_cfg_wr_en,
    input  wire [hgg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [hgg_pkg::DUTY_W-1:0]            i_cfg_wdata,
    // input beats
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire [hgg_pkg::IN_DATA_W-1:0]         s_axis_tdata,  // elapsed_ms[15:0], mode[17:16], pad
    input  wire                                  s_axis_tuser,  // kind
    // output beats
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [hgg_pkg::OUT_DATA_W-1:0]       m_axis_tdata   // front_left, front_right,
                                                                // rear_left, rear_right
);
    import hgg_pkg::*;

    // configuration registers
    logic [MS_W-1:0]   r_period;
    logic [DUTY_W-1:0] r_swing;
    logic [DUTY_W-1:0] r_stand;
    logic [DUTY_W-1:0] r_min;
    logic [DUTY_W-1:0] r_max;

    // control state
    t_state            r_state, n_state;
    t_mode             r_mode;
    logic [MS_W-1:0]   r_phase;
    logic              r_out_valid;

    // payload
    logic signed [POSE_W-1:0] r_pose [NUM_LEGS];  // FL, FR, RL, RR before clamp
    logic [OUT_DATA_W-1:0]    r_out_data;

    logic              in_acc;
    logic              in_kind;
    logic [MS_W-1:0]   in_elapsed;
    t_mode             in_mode;

    logic [MS_W-1:0]   per_eff;
    logic [HALF_W-1:0] half;

    logic              mod_start;
    logic              mod_done;
    logic [MS_W-1:0]   mod_rem;
    logic [SUM_W-1:0]  q_b_sum;
    logic [MS_W-1:0]   q_b;

    t_lane_req         lane_a_req, lane_b_req;
    logic              lane_a_done, lane_b_done;
    logic signed [WAVE_W-1:0] wave_a, wave_b;
    logic signed [POSE_W-1:0] dir_a, dir_b;
    logic signed [POSE_W-1:0] stand_s;

    logic              out_load;

    assign in_kind    = s_axis_tuser;
    assign in_elapsed = s_axis_tdata[MS_W-1:0];
    assign in_mode    = t_mode'(s_axis_tdata[MS_W+1:MS_W]);
    assign in_acc     = s_axis_tvalid && s_axis_tready;

    // a period of 0 or 1 runs as 2
    assign per_eff = (r_period < MIN_PERIOD) ? MIN_PERIOD : r_period;
    assign half    = per_eff[MS_W-1:1];

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RST_PERIOD;
            r_swing  <= RST_SWING;
            r_stand  <= RST_STAND;
            r_min    <= RST_MIN;
            r_max    <= RST_MAX;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PERIOD: r_period <= i_cfg_wdata;
                CFG_SWING:  r_swing  <= i_cfg_wdata;
                CFG_STAND:  r_stand  <= i_cfg_wdata;
                CFG_MIN:    r_min    <= i_cfg_wdata;
                CFG_MAX:    r_max    <= i_cfg_wdata;
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_kind == KIND_SET) begin
                        if (in_mode == MODE_STAND || in_mode == MODE_PRONE)
                            n_state = ST_EMIT;
                    end else if (r_mode == MODE_FWD || r_mode == MODE_BACK) begin
                        n_state = ST_MOD;
                    end
                end
            end
            ST_MOD:  if (mod_done) n_state = ST_WAVE;
            ST_WAVE: if (lane_a_done) n_state = ST_EMIT;
            ST_EMIT: if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        mod_start     = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                mod_start     = s_axis_tvalid && in_kind == KIND_TICK
                              && (r_mode == MODE_FWD || r_mode == MODE_BACK);
            end
            ST_EMIT: out_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_STAND;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc && in_kind == KIND_SET) begin
                r_mode <= in_mode;
                if (in_mode == MODE_FWD || in_mode == MODE_BACK)
                    r_phase <= '0;
            end
            if (r_state == ST_MOD && mod_done)
                r_phase <= mod_rem;
        end
    end

    // ---------------- phase fold ----------------
    hgg_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend ({1'b0, r_phase} + {1'b0, in_elapsed}),
        .i_divisor  (per_eff),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // second lane samples half a period later, folded once
    assign q_b_sum = {1'b0, mod_rem} + {2'b00, half};
    assign q_b     = (q_b_sum >= {1'b0, per_eff})
                   ? MS_W'(q_b_sum - {1'b0, per_eff}) : q_b_sum[MS_W-1:0];

    always_comb begin
        lane_a_req.start = (r_state == ST_MOD) && mod_done;
        lane_a_req.q     = mod_rem;
        lane_a_req.half  = half;
        lane_a_req.swing = r_swing;
        lane_b_req       = lane_a_req;
        lane_b_req.q     = q_b;
    end

    hgg_wave_lane u_lane_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lane_a_req),
        .o_done  (lane_a_done),
        .o_wave  (wave_a)
    );

    hgg_wave_lane u_lane_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lane_b_req),
        .o_done  (lane_b_done),
        .o_wave  (wave_b)
    );

    // ---------------- pose ----------------
    assign stand_s = $signed({3'b000, r_stand});
    // walking back flips the sign of both waves
    assign dir_a = (r_mode == MODE_BACK) ? -$signed({wave_a[WAVE_W-1], wave_a})
                                         :  $signed({wave_a[WAVE_W-1], wave_a});
    assign dir_b = (r_mode == MODE_BACK) ? -$signed({wave_b[WAVE_W-1], wave_b})
                                         :  $signed({wave_b[WAVE_W-1], wave_b});

    always_ff @(posedge i_clk) begin
        if (in_acc && in_kind == KIND_SET) begin
            if (in_mode == MODE_PRONE) begin
                r_pose[0] <= $signed({3'b000, r_min});
                r_pose[1] <= $signed({3'b000, r_max});
                r_pose[2] <= $signed({3'b000, r_max});
                r_pose[3] <= $signed({3'b000, r_min});
            end else begin
                r_pose[0] <= stand_s;
                r_pose[1] <= stand_s;
                r_pose[2] <= stand_s;
                r_pose[3] <= stand_s;
            end
        end else if (r_state == ST_WAVE && lane_a_done) begin
            r_pose[0] <= stand_s - dir_a;   // front left
            r_pose[1] <= stand_s + dir_b;   // front right
            r_pose[2] <= stand_s - dir_b;   // rear left
            r_pose[3] <= stand_s + dir_a;   // rear right
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {clamp_duty(r_pose[3], r_min, r_max),
                           clamp_duty(r_pose[2], r_min, r_max),
                           clamp_duty(r_pose[1], r_min, r_max),
                           clamp_duty(r_pose[0], r_min, r_max)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_a_done == lane_b_done)
        else $error("wave lanes out of step");

    a_wave_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_a_done |-> (wave_a <= $signed({2'b00, r_swing})
                         && wave_a >= -$signed({2'b00, r_swing})))
        else $error("wave sample beyond swing");

    a_phase_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAVE) |-> (r_phase < per_eff))
        else $error("phase not folded into period");

    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_out_valid && !m_axis_tready) |=> (r_state == ST_EMIT))
        else $error("result dropped while output full");

endmodule

`default_nettype wire

// ===== dv/quadruped_hip_gait_generator_tb.sv =====
// ----------------------------------------------------------------------------
// quadruped_hip_gait_generator_tb: self-checking bench for the hip gait block
// Drives tick and mode beats, mirrors the mode, phase and triangle wave in a
// local predictor, and compares every output beat leg by leg.
// ----------------------------------------------------------------------------
`default_nettype none

module quadruped_hip_gait_generator_tb;

    import hgg_pkg::*;

    // one output beat: leg 0 = front left in the low bits, then FR, RL, RR
    typedef logic [NUM_LEGS-1:0][DUTY_W-1:0] hip_set_t;

    localparam int SETTLE_CYCLES = 80;   // outlasts a walk tick's trip to its output beat
    localparam int CHUNKS        = 16;
    localparam int CHUNK_ITEMS   = 90;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [DUTY_W-1:0]      i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;   // elapsed_ms[15:0], mode[17:16], pad
    logic                   s_axis_tuser  = 1'b0; // kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;         // front_left, front_right,
                                                  // rear_left, rear_right

    // predictor state: register copies plus mode and phase
    logic [MS_W-1:0]   cfg_period = RST_PERIOD;
    logic [DUTY_W-1:0] cfg_swing  = RST_SWING;
    logic [DUTY_W-1:0] cfg_stand  = RST_STAND;
    logic [DUTY_W-1:0] cfg_min    = RST_MIN;
    logic [DUTY_W-1:0] cfg_max    = RST_MAX;
    t_mode             gait_mode  = MODE_STAND;
    logic [MS_W-1:0]   gait_phase = '0;

    hip_set_t hip_q[$];          // duties still owed by the block
    int       live_items   = 0;  // beats that were not simply dropped
    int       err_cnt      = 0;
    int       src_idle_pct = 0;
    int       snk_stall_pct = 0;

    string leg_name [NUM_LEGS] = '{"front_left_duty", "front_right_duty",
                                   "rear_left_duty", "rear_right_duty"};

    quadruped_hip_gait_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // low limit first, then high: min > max pins every leg at max
    function automatic logic [DUTY_W-1:0] limit_duty(input longint v);
        longint r;
        r = v;
        if (r < longint'(cfg_min)) r = longint'(cfg_min);
        if (r > longint'(cfg_max)) r = longint'(cfg_max);
        return r[DUTY_W-1:0];
    endfunction

    // triangle: 0 -> +swing over first half, +swing -> -swing over second
    function automatic longint tri_wave(input longint p, input longint per);
        longint h, q, amp, x;
        h   = per / 2;
        q   = p % per;
        amp = longint'(cfg_swing);
        if (q < h) begin
            x = (amp * q) / h;
        end else begin
            x = amp - (2 * amp * (q - h)) / h;
        end
        if (x > amp)  x = amp;
        if (x < -amp) x = -amp;
        return x;
    endfunction

    // Called at the edge that accepts a beat; queues the duties it owes.
    function automatic void predict_hips(input logic kind, input logic [MS_W-1:0] ms,
                                         input t_mode md);
        hip_set_t pose;
        longint   per, h, t, a, b, s, dir;
        s = longint'(cfg_stand);
        if (kind == KIND_SET) begin
            gait_mode = md;
            live_items++;
            case (md)
                MODE_STAND: begin
                    for (int k = 0; k < NUM_LEGS; k++) pose[k] = limit_duty(s);
                    hip_q.push_back(pose);
                end
                MODE_PRONE: begin
                    pose[0] = limit_duty(longint'(cfg_min));
                    pose[1] = limit_duty(longint'(cfg_max));
                    pose[2] = limit_duty(longint'(cfg_max));
                    pose[3] = limit_duty(longint'(cfg_min));
                    hip_q.push_back(pose);
                end
                default: gait_phase = '0;   // entering a walk restarts the cycle
            endcase
        end else if (gait_mode == MODE_FWD || gait_mode == MODE_BACK) begin
            live_items++;
            // periods of 0 and 1 run as 2
            per = (cfg_period < MIN_PERIOD) ? longint'(MIN_PERIOD) : longint'(cfg_period);
            h   = per / 2;
            t   = (longint'(gait_phase) + longint'(ms)) % per;
            gait_phase = t[MS_W-1:0];
            dir = (gait_mode == MODE_FWD) ? 1 : -1;
            a   = dir * tri_wave(t, per);
            b   = dir * tri_wave(t + h, per);
            pose[0] = limit_duty(s - a);
            pose[1] = limit_duty(s + b);
            pose[2] = limit_duty(s - b);
            pose[3] = limit_duty(s + a);
            hip_q.push_back(pose);
        end
        // ticks in stand or prone: dropped, state untouched
    endfunction

    // ------------------------------------------------------------------
    // Sink side: random stall, checker on every accepted output beat
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin : check_duties
        hip_set_t want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (hip_q.size() == 0) begin
                $error("unexpected output beat %h", m_axis_tdata);
                err_cnt++;
            end else begin
                want = hip_q.pop_front();
                got  = m_axis_tdata;
                for (int k = 0; k < NUM_LEGS; k++) begin
                    if (got[k] !== want[k]) begin
                        $error("%s: expected %0d, actual %0d", leg_name[k], want[k], got[k]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Source side helpers; all entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_beat(input logic kind, input logic [MS_W-1:0] ms, input t_mode md);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= IN_DATA_W'({md, ms});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_hips(kind, ms, md);
        @(negedge i_clk);
    endtask

    // Stop sending, wait for every owed beat, then let a dropped item finish.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (hip_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // only while idle; indexes past the list are ignored by the block
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_PERIOD: cfg_period = val;
            CFG_SWING:  cfg_swing  = val;
            CFG_STAND:  cfg_stand  = val;
            CFG_MIN:    cfg_min    = val;
            CFG_MAX:    cfg_max    = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // mostly short steps through the cycle, sometimes half/full/random jumps
    function automatic logic [MS_W-1:0] pick_elapsed();
        int unsigned per;
        per = (cfg_period < MIN_PERIOD) ? MIN_PERIOD : cfg_period;
        case ($urandom_range(9))
            0:       return MS_W'($urandom_range(65535));
            1:       return MS_W'(per / 2);
            2:       return MS_W'(per - 1);
            default: return MS_W'($urandom_range((per > 64) ? per / 8 : per, 0));
        endcase
    endfunction

    task automatic randomize_config();
        logic [DUTY_W-1:0] lo, hi;
        case ($urandom_range(9))
            0:       write_reg(CFG_PERIOD, DUTY_W'($urandom_range(1)));
            1:       write_reg(CFG_PERIOD, 16'hFFFF);
            2:       write_reg(CFG_PERIOD, DUTY_W'($urandom_range(65535)));
            default: write_reg(CFG_PERIOD, DUTY_W'($urandom_range(400, 2)));
        endcase
        case ($urandom_range(9))
            0:       write_reg(CFG_SWING, '0);
            1:       write_reg(CFG_SWING, 16'hFFFF);
            2, 3:    write_reg(CFG_SWING, DUTY_W'($urandom_range(65535)));
            default: write_reg(CFG_SWING, DUTY_W'($urandom_range(3000)));
        endcase
        write_reg(CFG_STAND, ($urandom_range(1) != 0) ? DUTY_W'($urandom_range(65535))
                                                      : DUTY_W'($urandom_range(6000, 3000)));
        case ($urandom_range(9))
            0: begin                                // inverted limits
                hi = DUTY_W'($urandom_range(30000));
                lo = DUTY_W'($urandom_range(65535, 30001));
            end
            1: begin
                lo = '0;
                hi = 16'hFFFF;
            end
            default: begin
                lo = DUTY_W'($urandom_range(30000));
                hi = DUTY_W'($urandom_range(65535, lo));
            end
        endcase
        write_reg(CFG_MIN, lo);
        write_reg(CFG_MAX, hi);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset settings: both poses, a walk each way across the whole cycle
    task automatic test_directed_poses();
        send_beat(KIND_SET,  16'hFFFF, MODE_STAND);
        send_beat(KIND_SET,  16'h0000, MODE_PRONE);
        send_beat(KIND_TICK, 16'd100,  MODE_BACK);     // dropped in prone
        send_beat(KIND_SET,  16'h0000, MODE_FWD);
        send_beat(KIND_TICK, 16'd0,    MODE_STAND);
        send_beat(KIND_TICK, 16'd750,  MODE_STAND);
        send_beat(KIND_TICK, 16'd750,  MODE_PRONE);    // exactly half a cycle
        send_beat(KIND_TICK, 16'd1499, MODE_FWD);      // last ms of the cycle
        send_beat(KIND_TICK, 16'hFFFF, MODE_BACK);
        send_beat(KIND_SET,  16'h1234, MODE_BACK);
        send_beat(KIND_TICK, 16'd1,    MODE_STAND);
        send_beat(KIND_TICK, 16'd2250, MODE_STAND);
        send_beat(KIND_TICK, 16'd749,  MODE_STAND);
        send_beat(KIND_SET,  16'h0000, MODE_STAND);
        send_beat(KIND_TICK, 16'd5,    MODE_FWD);      // dropped in stand
        drain_block();
    endtask

    task automatic test_special_cases();
        // inverted limits: every leg lands on max
        write_reg(CFG_MIN, 16'd60000);
        write_reg(CFG_MAX, 16'd100);
        send_beat(KIND_SET,  16'h0000, MODE_STAND);
        send_beat(KIND_SET,  16'h0000, MODE_PRONE);
        send_beat(KIND_SET,  16'h0000, MODE_FWD);
        send_beat(KIND_TICK, 16'd10,   MODE_STAND);
        drain_block();
        write_reg(CFG_MIN, RST_MIN);
        write_reg(CFG_MAX, RST_MAX);

        // period 0 and 1 behave as 2
        write_reg(CFG_PERIOD, 16'd0);
        send_beat(KIND_SET,  16'h0000, MODE_BACK);
        send_beat(KIND_TICK, 16'd1,    MODE_STAND);
        send_beat(KIND_TICK, 16'd3,    MODE_STAND);
        drain_block();
        write_reg(CFG_PERIOD, 16'd1);
        send_beat(KIND_TICK, 16'd1,    MODE_STAND);
        send_beat(KIND_TICK, 16'd2,    MODE_STAND);
        drain_block();

        // phase left beyond a shortened period gets folded back
        write_reg(CFG_PERIOD, 16'd60000);
        send_beat(KIND_SET,  16'h0000, MODE_FWD);
        send_beat(KIND_TICK, 16'd50000, MODE_STAND);
        drain_block();
        write_reg(CFG_PERIOD, 16'd100);
        send_beat(KIND_TICK, 16'd0,    MODE_STAND);
        send_beat(KIND_TICK, 16'd37,   MODE_STAND);
        drain_block();

        // writes to unused indexes must not disturb anything
        for (int k = CFG_MAX + 1; k < 2 ** CFG_IDX_W; k++) begin
            write_reg(CFG_IDX_W'(k), (k % 2 != 0) ? 16'hFFFF : 16'h0000);
        end
        send_beat(KIND_SET,  16'h0000, MODE_STAND);
        send_beat(KIND_SET,  16'h0000, MODE_PRONE);
        drain_block();

        // full-scale swing, open limits, both stand extremes
        write_reg(CFG_PERIOD, 16'hFFFF);
        write_reg(CFG_SWING,  16'hFFFF);
        write_reg(CFG_STAND,  16'h0000);
        write_reg(CFG_MIN,    16'h0000);
        write_reg(CFG_MAX,    16'hFFFF);
        send_beat(KIND_SET,  16'h0000, MODE_FWD);
        send_beat(KIND_TICK, 16'd0,     MODE_STAND);
        send_beat(KIND_TICK, 16'd16383, MODE_STAND);
        send_beat(KIND_TICK, 16'd16384, MODE_STAND);
        send_beat(KIND_TICK, 16'hFFFF,  MODE_STAND);
        drain_block();
        write_reg(CFG_STAND, 16'hFFFF);
        send_beat(KIND_SET,  16'h0000, MODE_BACK);
        send_beat(KIND_TICK, 16'd32767, MODE_STAND);
        drain_block();
        write_reg(CFG_SWING, 16'h0000);
        send_beat(KIND_TICK, 16'd5,    MODE_STAND);
        drain_block();
    endtask

    // Chunks of mostly well-formed walks under a fresh setting each time,
    // cycling through the four idle/stall profiles.
    task automatic test_random_gait();
        int target, pick;
        for (int c = 0; c < CHUNKS; c++) begin
            case (c % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 60; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 60; end
                default: begin src_idle_pct = 10; snk_stall_pct = 10; end
            endcase
            randomize_config();
            target = live_items + CHUNK_ITEMS;
            while (live_items < target) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    send_beat(KIND_SET, MS_W'($urandom_range(65535)),
                              ($urandom_range(1) != 0) ? MODE_FWD : MODE_BACK);
                    repeat ($urandom_range(30, 3)) begin
                        send_beat(KIND_TICK, pick_elapsed(), t_mode'($urandom_range(3)));
                    end
                end else if (pick < 90) begin
                    send_beat(KIND_SET, MS_W'($urandom_range(65535)),
                              ($urandom_range(1) != 0) ? MODE_STAND : MODE_PRONE);
                    repeat ($urandom_range(3)) begin
                        send_beat(KIND_TICK, MS_W'($urandom_range(65535)),
                                  t_mode'($urandom_range(3)));
                    end
                end else if (pick < 97) begin
                    // noise: any kind, any mode, any elapsed
                    repeat ($urandom_range(4, 1)) begin
                        send_beat(logic'($urandom_range(1)), MS_W'($urandom_range(65535)),
                                  t_mode'($urandom_range(3)));
                    end
                end else begin
                    drain_block();     // sender holds off until all beats are back
                end
            end
            drain_block();
        end
        src_idle_pct  = 0;
        snk_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_poses();
        test_special_cases();
        test_random_gait();
        drain_block();
        if (err_cnt == 0) begin
            $display("quadruped_hip_gait_generator_tb: clean");
        end else begin
            $display("quadruped_hip_gait_generator_tb: errors");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #12_000_000;
        $display("quadruped_hip_gait_generator_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
